// ===== rtl/cvlfo_pkg.sv =====
// ============================================================================
// cvlfo_pkg: shared types and constants of the control-voltage LFO bank
// Holds the sequencer state type, the register map and the fixed widths and
// reset values of the period and averaging logic.
// ============================================================================
package cvlfo_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SAMPLE,
        S_DIV,
        S_DONE
    } t_state;

    // Input action codes.
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Configuration register map.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_NUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CV     = 2'd2;

    // Register widths and reset values.
    localparam int DEPTH_W  = 3;
    localparam int NUM_W    = 16;
    localparam int MIN_CV_W = 10;
    localparam logic [DEPTH_W-1:0]  MAX_DEPTH       = 3'd6;
    localparam logic [NUM_W-1:0]    RESET_NUMERATOR = 16'd12904;
    localparam logic [MIN_CV_W-1:0] RESET_MIN_CV    = 10'd25;

    // Averaging counter and LFO period.
    localparam int LEFT_W   = 7;
    localparam int PERIOD_W = 10;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 10'd1023;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 10'd51;

    // First converter channel that drives an LFO.
    localparam int FIRST_LFO_CH = 4;

    // Sequencer step counter and the number of division iterations.
    localparam int STEP_W    = 4;
    localparam int DIV_STEPS = 16;

endpackage

// ===== rtl/cvlfo_sub_unit.sv =====
// ============================================================================
// cvlfo_sub_unit: shared subtractor
// One unsigned subtractor with borrow, used both for the restoring division
// steps and for decrementing the LFO counters one at a time.
// ============================================================================
module cvlfo_sub_unit #(
    parameter int WIDTH = 11
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow
);

    logic [WIDTH:0] full_diff;

    // Widen by one bit so that the top bit is the borrow.
    assign full_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff    = full_diff[WIDTH-1:0];
    assign o_borrow  = full_diff[WIDTH];

endmodule

// ===== rtl/cv_controlled_square_lfo_bank_unit.sv =====
// ============================================================================
// cv_controlled_square_lfo_bank_unit: bank of square LFOs with CV-set rates
// Averages converter samples per channel, turns readings on the LFO channels
// into periods with a bit-serial divider and steps the LFO counters on ticks.
// ============================================================================
// On a tick one shared subtractor updates one counter per cycle. A sample is
// averaged or compared first and, when its reading sets a new LFO period, then
// goes through the restoring divider on the same unit. The result is registered:
// the done state loads the output register once the output is free; the next item is
// accepted while the result waits. Synchronous active-low reset clears all
// readings, sums and levels and loads every period and counter with 51.
module cv_controlled_square_lfo_bank_unit #(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_LFOS     = 4,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [$clog2(NUM_CHANNELS)-1:0]     i_channel,
    input  logic [SAMPLE_BITS-1:0]              i_sample_value,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [NUM_LFOS-1:0]                 o_lfo_levels,
    output logic                                o_reading_valid,
    output logic [$clog2(NUM_CHANNELS)-1:0]     o_reading_channel,
    output logic [SAMPLE_BITS-1:0]              o_reading_value,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cvlfo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cvlfo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import cvlfo_pkg::*;

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int LFO_IDX_W = (NUM_LFOS > 1) ? $clog2(NUM_LFOS) : 1;
    localparam int CV_W      = (SAMPLE_BITS > MIN_CV_W) ? SAMPLE_BITS : MIN_CV_W;
    localparam int SUM_W     = SAMPLE_BITS + int'(MAX_DEPTH);
    localparam int SUB_W     = CV_W + 1;

    // Sequencer.
    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // Item being worked on.
    logic [CH_W-1:0]        r_ch, n_ch;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic                   r_rd_valid, n_rd_valid;
    logic [SAMPLE_BITS-1:0] r_rd_val, n_rd_val;

    // Divider registers.
    logic [LFO_IDX_W-1:0] r_lfo_sel, n_lfo_sel;
    logic [CV_W-1:0]      r_rem, n_rem;
    logic [CV_W-1:0]      r_divisor, n_divisor;
    logic [NUM_W-1:0]     r_div_num, n_div_num;
    logic [NUM_W-1:0]     r_quot, n_quot;

    // Configuration registers.
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [MIN_CV_W-1:0] r_min_cv, n_min_cv;

    // Channel and LFO state.
    logic [SAMPLE_BITS-1:0] r_readings [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] n_readings [NUM_CHANNELS];
    logic [SUM_W-1:0]       r_sums     [NUM_CHANNELS];
    logic [SUM_W-1:0]       n_sums     [NUM_CHANNELS];
    logic [LEFT_W-1:0]      r_left     [NUM_CHANNELS];
    logic [LEFT_W-1:0]      n_left     [NUM_CHANNELS];
    logic [PERIOD_W-1:0]    r_periods  [NUM_LFOS];
    logic [PERIOD_W-1:0]    n_periods  [NUM_LFOS];
    logic [PERIOD_W-1:0]    r_cnt      [NUM_LFOS];
    logic [PERIOD_W-1:0]    n_cnt      [NUM_LFOS];
    logic [NUM_LFOS-1:0]    r_lfo_out, n_lfo_out;

    // Output register.
    logic                   r_out_valid, n_out_valid;
    logic [NUM_LFOS-1:0]    r_out_levels, n_out_levels;
    logic                   r_out_rd_valid, n_out_rd_valid;
    logic [CH_W-1:0]        r_out_ch, n_out_ch;
    logic [SAMPLE_BITS-1:0] r_out_val, n_out_val;

    // Shared subtractor.
    logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
    logic             sub_borrow;

    // Status towards the sequencer and handshake strobes.
    logic in_accept, out_free, out_load, tick_last, div_last, samp_div;

    // Work signals.
    logic [LFO_IDX_W-1:0]   tick_idx;
    logic [PERIOD_W-1:0]    cnt_cur;
    logic [DEPTH_W-1:0]     depth_used, cfg_depth;
    logic [SUM_W-1:0]       sum_new, sum_shift;
    logic                   ch_ok, is_lfo, upd;
    logic [SAMPLE_BITS-1:0] new_val;
    logic [MIN_CV_W-1:0]    floor_cv;
    logic [CV_W-1:0]        cv_val, cv_floor;
    logic [NUM_W-1:0]       quot_next;
    logic [PERIOD_W-1:0]    period_sat;

    cvlfo_sub_unit #(
        .WIDTH (SUB_W)
    ) u_sub (
        .i_a      (sub_a),
        .i_b      (sub_b),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    // Handshake strobes and status.
    assign in_accept = (r_state == S_IDLE) && i_in_valid;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign tick_last = (r_step == STEP_W'(NUM_LFOS - 1));
    assign div_last  = (r_step == STEP_W'(DIV_STEPS - 1));
    assign tick_idx  = r_step[LFO_IDX_W-1:0];
    assign cnt_cur   = r_cnt[tick_idx];

    // Operand selection for the shared subtractor.
    always_comb begin
        case (r_state)
            S_TICK: begin
                sub_a = SUB_W'(cnt_cur);
                sub_b = SUB_W'(cnt_cur != '0);
            end
            default: begin
                sub_a = {r_rem, r_div_num[NUM_W-1]};
                sub_b = {1'b0, r_divisor};
            end
        endcase
    end

    // Sample evaluation terms.
    always_comb begin
        depth_used = (r_depth > MAX_DEPTH) ? MAX_DEPTH : r_depth;
        ch_ok      = (32'(r_ch) < NUM_CHANNELS);
        is_lfo     = (32'(r_ch) >= FIRST_LFO_CH) &&
                     (32'(r_ch) - FIRST_LFO_CH < NUM_LFOS);
        sum_new    = r_sums[r_ch] + SUM_W'(r_sample);
        sum_shift  = sum_new >> depth_used;
        upd        = 1'b0;
        new_val    = r_readings[r_ch];
        if (ch_ok) begin
            if (depth_used == '0) begin
                upd     = (r_readings[r_ch] != r_sample);
                new_val = r_sample;
            end else if (r_left[r_ch] <= LEFT_W'(1)) begin
                upd     = 1'b1;
                new_val = sum_shift[SAMPLE_BITS-1:0];
            end
        end
        samp_div = upd && is_lfo;
        floor_cv = (r_min_cv == '0) ? MIN_CV_W'(1) : r_min_cv;
        cv_val   = CV_W'(new_val);
        cv_floor = CV_W'(floor_cv);
        if (cv_val < cv_floor) begin
            cv_val = cv_floor;
        end
    end

    // Quotient after this division step and the clamped period.
    always_comb begin
        quot_next = {r_quot[NUM_W-2:0], !sub_borrow};
        if (quot_next > NUM_W'(PERIOD_MAX)) begin
            period_sat = PERIOD_MAX;
        end else if (quot_next == '0) begin
            period_sat = PERIOD_W'(1);
        end else begin
            period_sat = quot_next[PERIOD_W-1:0];
        end
        cfg_depth = (i_cfg_data[DEPTH_W-1:0] > MAX_DEPTH) ?
                    MAX_DEPTH : i_cfg_data[DEPTH_W-1:0];
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_action == ACT_TICK) ? S_TICK : S_SAMPLE;
                end
            end
            S_TICK: begin
                if (tick_last) begin
                    n_state = S_DONE;
                end
            end
            S_SAMPLE: begin
                n_state = samp_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        out_load   = (r_state == S_DONE) && out_free;
    end

    // Datapath next values.
    always_comb begin
        n_step     = r_step;
        n_ch       = r_ch;
        n_sample   = r_sample;
        n_rd_valid = r_rd_valid;
        n_rd_val   = r_rd_val;
        n_lfo_sel  = r_lfo_sel;
        n_rem      = r_rem;
        n_divisor  = r_divisor;
        n_div_num  = r_div_num;
        n_quot     = r_quot;
        n_depth    = r_depth;
        n_num      = r_num;
        n_min_cv   = r_min_cv;
        n_readings = r_readings;
        n_sums     = r_sums;
        n_left     = r_left;
        n_periods  = r_periods;
        n_cnt      = r_cnt;
        n_lfo_out  = r_lfo_out;

        case (r_state)
            // Capture a new transaction.
            S_IDLE: begin
                if (in_accept) begin
                    n_ch       = i_channel;
                    n_sample   = i_sample_value;
                    n_step     = '0;
                    n_rd_valid = 1'b0;
                    n_rd_val   = '0;
                end
            end
            // One LFO counter per cycle through the shared subtractor.
            S_TICK: begin
                n_step = r_step + STEP_W'(1);
                if (sub_diff[PERIOD_W-1:0] == '0) begin
                    n_lfo_out[tick_idx] = !r_lfo_out[tick_idx];
                    n_cnt[tick_idx]     = r_periods[tick_idx];
                end else begin
                    n_cnt[tick_idx] = sub_diff[PERIOD_W-1:0];
                end
            end
            // Averaging or change detection, then set up the divider.
            S_SAMPLE: begin
                if (ch_ok && depth_used != '0) begin
                    if (r_left[r_ch] > LEFT_W'(1)) begin
                        n_sums[r_ch] = sum_new;
                        n_left[r_ch] = r_left[r_ch] - LEFT_W'(1);
                    end else begin
                        n_sums[r_ch] = '0;
                        n_left[r_ch] = LEFT_W'(1) << depth_used;
                    end
                end
                if (upd) begin
                    n_readings[r_ch] = new_val;
                    n_rd_valid       = 1'b1;
                    n_rd_val         = new_val;
                end
                n_step    = '0;
                n_lfo_sel = LFO_IDX_W'(32'(r_ch) - FIRST_LFO_CH);
                n_rem     = '0;
                n_divisor = cv_val;
                n_div_num = r_num;
                n_quot    = '0;
            end
            // One restoring division step per cycle.
            S_DIV: begin
                n_step    = r_step + STEP_W'(1);
                n_div_num = {r_div_num[NUM_W-2:0], 1'b0};
                n_quot    = quot_next;
                n_rem     = sub_borrow ? sub_a[CV_W-1:0] : sub_diff[CV_W-1:0];
                if (div_last) begin
                    n_periods[r_lfo_sel] = period_sat;
                end
            end
            default: begin
            end
        endcase

        // The user must write configuration only while the block is idle; the block does not enforce it.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AVG_DEPTH: begin
                    n_depth = i_cfg_data[DEPTH_W-1:0];
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        n_sums[c] = '0;
                        n_left[c] = LEFT_W'(1) << cfg_depth;
                    end
                end
                CFG_PERIOD_NUM: begin
                    n_num = i_cfg_data[NUM_W-1:0];
                end
                CFG_MIN_CV: begin
                    n_min_cv = i_cfg_data[MIN_CV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Output register next values.
    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_levels   = r_out_levels;
        n_out_rd_valid = r_out_rd_valid;
        n_out_ch       = r_out_ch;
        n_out_val      = r_out_val;
        if (out_load) begin
            n_out_valid    = 1'b1;
            n_out_levels   = r_lfo_out;
            n_out_rd_valid = r_rd_valid;
            n_out_ch       = r_rd_valid ? r_ch : '0;
            n_out_val      = r_rd_val;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and architectural state, set to its reset values by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_num       <= RESET_NUMERATOR;
            r_min_cv    <= RESET_MIN_CV;
            r_lfo_out   <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_readings[c] <= '0;
                r_sums[c]     <= '0;
                r_left[c]     <= LEFT_W'(1);
            end
            for (int l = 0; l < NUM_LFOS; l++) begin
                r_periods[l] <= RESET_PERIOD;
                r_cnt[l]     <= RESET_PERIOD;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_depth     <= n_depth;
            r_num       <= n_num;
            r_min_cv    <= n_min_cv;
            r_lfo_out   <= n_lfo_out;
            r_readings  <= n_readings;
            r_sums      <= n_sums;
            r_left      <= n_left;
            r_periods   <= n_periods;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ch           <= n_ch;
        r_sample       <= n_sample;
        r_rd_valid     <= n_rd_valid;
        r_rd_val       <= n_rd_val;
        r_lfo_sel      <= n_lfo_sel;
        r_rem          <= n_rem;
        r_divisor      <= n_divisor;
        r_div_num      <= n_div_num;
        r_quot         <= n_quot;
        r_out_levels   <= n_out_levels;
        r_out_rd_valid <= n_out_rd_valid;
        r_out_ch       <= n_out_ch;
        r_out_val      <= n_out_val;
    end

    // Ports.
    assign o_out_valid       = r_out_valid;
    assign o_lfo_levels      = r_out_levels;
    assign o_reading_valid   = r_out_rd_valid;
    assign o_reading_channel = r_out_ch;
    assign o_reading_value   = r_out_val;
    assign o_cfg_ready       = 1'b1;

    // The block is busy in the cycle after it accepts a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on two consecutive cycles");

    // A result without a reading carries zero channel and value.
    a_no_reading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reading_valid) |->
        (o_reading_channel == '0 && o_reading_value == '0))
        else $error("reading fields set without a reading");

    // A reported reading always belongs to an existing channel.
    a_reading_channel_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading_valid) |-> (32'(o_reading_channel) < NUM_CHANNELS))
        else $error("reading reported on a missing channel");

endmodule
